// File: hw/rtl/scl2x_pkg.sv
// Shared constants, types and pixel functions for the Scale2x upscaler.
// Used by every module of the block but the RAM; depends on nothing else.
package scl2x_pkg;

   localparam int PIXEL_W     = 32;
   localparam int POS_W       = 10;
   localparam int BPP_W       = 3;
   localparam int DIM_W       = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int COUNT_W     = 2;
   localparam int QUADS_MAX   = 3;
   localparam int RSP_TDATA_W = 152;

   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 1024;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd2;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd640;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd480;
   localparam logic [BPP_W-1:0] RESET_BPP    = 3'd4;

   typedef struct packed {
      logic [PIXEL_W-1:0] br;
      logic [PIXEL_W-1:0] bl;
      logic [PIXEL_W-1:0] tr;
      logic [PIXEL_W-1:0] tl;
   } pix4_type;

   typedef struct packed {
      logic             eoi;
      pix4_type         pix;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
   } quad_type;

   typedef struct packed {
      logic               load;
      logic [COUNT_W-1:0] count;
   } batch_type;

   // Scale2x rule: each corner copies a neighbour when the two adjacent
   // edges agree and the opposite ones differ, otherwise the centre.
   function automatic pix4_type epx_quad(input logic [PIXEL_W-1:0] b,
                                         input logic [PIXEL_W-1:0] d,
                                         input logic [PIXEL_W-1:0] e,
                                         input logic [PIXEL_W-1:0] f,
                                         input logic [PIXEL_W-1:0] h);
      pix4_type q;
      q.tl = (d == b && b != f && d != h) ? d : e;
      q.tr = (b == f && b != d && f != h) ? f : e;
      q.bl = (d == h && d != b && h != f) ? d : e;
      q.br = (h == f && d != h && b != f) ? f : e;
      return q;
   endfunction

   function automatic logic [PIXEL_W-1:0] mask_pixel(input logic [BPP_W-1:0] bpp,
                                                     input logic [PIXEL_W-1:0] pixel);
      logic [PIXEL_W-1:0] m;
      case (bpp)
         3'd1:    m = 32'h0000_00FF;
         3'd2:    m = 32'h0000_FFFF;
         3'd3:    m = 32'h00FF_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return pixel & m;
   endfunction

endpackage

// File: hw/rtl/scl2x_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for both line stores of the upscaler.
module scl2x_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/scl2x_lines.sv
// Raster position counters, the two line stores and the neighbour stage that
// forms up to three quads per request. Depends on scl2x_pkg and scl2x_ram.
module scl2x_lines #(
   parameter int MAX_WIDTH  = scl2x_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = scl2x_pkg::DEFAULT_MAX_HEIGHT,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int WW = CW + 1,
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
   localparam int HW = RW + 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           restart,
   input  logic [WW-1:0]                  eff_w,
   input  logic [HW-1:0]                  eff_h,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [scl2x_pkg::PIXEL_W-1:0]  in_pixel,
   input  logic                           out_ready,
   output scl2x_pkg::batch_type           batch,
   output scl2x_pkg::quad_type            quads [scl2x_pkg::QUADS_MAX]
);

   typedef struct packed {
      logic row_ge1;
      logic row_ge2;
      logic col_ge1;
      logic col_ge2;
      logic has_right;
      logic last_row;
      logic row_end;
   } flags_type;

   // Position of the next request
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // Neighbour stage
   logic                           s1_valid_ff, s1_valid_in;
   logic [scl2x_pkg::PIXEL_W-1:0]  s1_pix_ff;
   logic [CW-1:0]                  s1_col_ff;
   flags_type                      s1_flags_ff, flags_now;
   logic [scl2x_pkg::POS_W-1:0]    s1_row_ff, s1_rowm1_ff, s1_colp_ff, s1_colm1_ff;
   logic                           s1_nfwd_ff, s1_ofwd_ff;
   logic [scl2x_pkg::PIXEL_W-1:0]  ofwd_data_ff;
   logic [scl2x_pkg::PIXEL_W-1:0]  e_hold_ff, rec0_ff, rec1_ff, rec2_ff;

   logic                           accept, advance;
   logic [WW-1:0]                  col_plus1;
   logic [HW-1:0]                  row_plus1;
   logic [CW-1:0]                  newer_raddr;
   logic                           older_we;
   logic [scl2x_pkg::PIXEL_W-1:0]  older_rdata, newer_rdata, older_rd, newer_rd;
   logic [scl2x_pkg::PIXEL_W-1:0]  p, ea, ba, da, fa, eb, db, bb, dc, bc;
   logic                           has_a, has_b, has_c;
   scl2x_pkg::quad_type            qa, qb, qc;
   logic [scl2x_pkg::COUNT_W-1:0]  count;

   assign col_plus1 = {1'b0, col_ff} + WW'(1);
   assign row_plus1 = {1'b0, row_ff} + HW'(1);

   always_comb begin
      flags_now.row_ge1   = (row_ff != '0);
      flags_now.row_ge2   = ({1'b0, row_ff} >= HW'(2));
      flags_now.col_ge1   = (col_ff != '0);
      flags_now.col_ge2   = ({1'b0, col_ff} >= WW'(2));
      flags_now.has_right = (col_plus1 < eff_w);
      flags_now.last_row  = (row_plus1 == eff_h);
      flags_now.row_end   = (col_plus1 == eff_w);
   end

   assign advance  = s1_valid_ff && (count == '0 || out_ready);
   assign in_ready = !s1_valid_ff || advance;
   assign accept   = in_valid && in_ready;

   // At a row end the read fetches column zero, the first centre of the next row.
   assign newer_raddr = flags_now.row_end ? '0 : col_plus1[CW-1:0];

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (flags_now.row_end) begin
            col_in = '0;
            row_in = flags_now.last_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_plus1[CW-1:0];
         end
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff    <= in_pixel;
         s1_col_ff    <= col_ff;
         s1_flags_ff  <= flags_now;
         s1_row_ff    <= scl2x_pkg::POS_W'(row_ff);
         s1_rowm1_ff  <= scl2x_pkg::POS_W'(row_ff - RW'(1));
         s1_colp_ff   <= scl2x_pkg::POS_W'(col_ff);
         s1_colm1_ff  <= scl2x_pkg::POS_W'(col_ff - CW'(1));
         s1_nfwd_ff   <= (newer_raddr == col_ff);
         s1_ofwd_ff   <= older_we && (s1_col_ff == col_ff);
         ofwd_data_ff <= ea;
      end
      if (advance) begin
         e_hold_ff <= newer_rd;
         if (s1_flags_ff.row_ge1) begin
            rec0_ff <= ea;
         end
         rec2_ff <= rec1_ff;
         rec1_ff <= s1_pix_ff;
      end
   end

   assign older_we = advance && s1_flags_ff.row_ge1;

   scl2x_ram #(
      .WIDTH (scl2x_pkg::PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_older (
      .clock (clock),
      .we    (older_we),
      .waddr (s1_col_ff),
      .wdata (ea),
      .re    (accept),
      .raddr (col_ff),
      .rdata (older_rdata)
   );

   scl2x_ram #(
      .WIDTH (scl2x_pkg::PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_newer (
      .clock (clock),
      .we    (accept),
      .waddr (col_ff),
      .wdata (in_pixel),
      .re    (accept),
      .raddr (newer_raddr),
      .rdata (newer_rdata)
   );

   // Reads that met a write to the same entry in the same cycle take the new data.
   assign older_rd = s1_ofwd_ff ? ofwd_data_ff : older_rdata;
   assign newer_rd = s1_nfwd_ff ? s1_pix_ff : newer_rdata;

   always_comb begin
      p  = s1_pix_ff;
      // Quad of the row above, completed by this pixel
      ea = e_hold_ff;
      ba = s1_flags_ff.row_ge2   ? older_rd : ea;
      da = s1_flags_ff.col_ge1   ? rec0_ff  : ea;
      fa = s1_flags_ff.has_right ? newer_rd : ea;
      // Delayed quad of the previous pixel in the last row
      eb = rec1_ff;
      db = s1_flags_ff.col_ge2 ? rec2_ff : eb;
      bb = s1_flags_ff.row_ge1 ? rec0_ff : eb;
      // Row-end quad of the last row
      dc = s1_flags_ff.col_ge1 ? rec1_ff : p;
      bc = s1_flags_ff.row_ge1 ? ea : p;

      qa.row = s1_rowm1_ff;
      qa.col = s1_colp_ff;
      qa.pix = scl2x_pkg::epx_quad(ba, da, ea, fa, p);
      qa.eoi = 1'b0;
      qb.row = s1_row_ff;
      qb.col = s1_colm1_ff;
      qb.pix = scl2x_pkg::epx_quad(bb, db, eb, p, eb);
      qb.eoi = 1'b0;
      qc.row = s1_row_ff;
      qc.col = s1_colp_ff;
      qc.pix = scl2x_pkg::epx_quad(bc, dc, p, p, p);
      qc.eoi = 1'b1;

      has_a = s1_flags_ff.row_ge1;
      has_b = s1_flags_ff.last_row && s1_flags_ff.col_ge1;
      has_c = s1_flags_ff.last_row && s1_flags_ff.row_end;
      count = scl2x_pkg::COUNT_W'(has_a) + scl2x_pkg::COUNT_W'(has_b)
            + scl2x_pkg::COUNT_W'(has_c);

      // Present quads are packed to the front in output order.
      quads[0] = has_a ? qa : (has_b ? qb : qc);
      quads[1] = (has_a && has_b) ? qb : qc;
      quads[2] = qc;
   end

   assign batch.load  = advance;
   assign batch.count = count;

endmodule

// File: hw/rtl/scl2x_outq.sv
// Result buffer: holds the quads of one request and hands them out one at
// a time on the response stream. Depends on scl2x_pkg.
module scl2x_outq (
   input  logic                           clock,
   input  logic                           reset,
   input  scl2x_pkg::batch_type           batch,
   input  scl2x_pkg::quad_type            quads [scl2x_pkg::QUADS_MAX],
   output logic                           ready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output scl2x_pkg::quad_type            rsp_quad,
   output logic                           rsp_last
);

   scl2x_pkg::quad_type            slot_ff [scl2x_pkg::QUADS_MAX];
   logic [scl2x_pkg::COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [scl2x_pkg::COUNT_W-1:0]  idx_ff, idx_in;
   logic                           fire, load;

   assign rsp_valid = (cnt_ff != '0);
   assign fire      = rsp_valid && rsp_ready;
   assign rsp_last  = (cnt_ff == scl2x_pkg::COUNT_W'(1));
   assign rsp_quad  = slot_ff[idx_ff];
   // A new set may enter as the final quad of the current one leaves.
   assign ready     = (cnt_ff == '0) || (rsp_last && rsp_ready);
   assign load      = batch.load && (batch.count != '0);

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = batch.count;
         idx_in = '0;
      end else if (fire) begin
         cnt_in = cnt_ff - scl2x_pkg::COUNT_W'(1);
         idx_in = idx_ff + scl2x_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= quads;
      end
   end

endmodule

// File: hw/rtl/scale2x_pixel_upscaler.sv
// Scale2x pixel upscaler, top level: register port, stream ports, packing.
// A request is registered in the neighbour stage and its quads in the result
// buffer, which offers them on rsp. Throughput: one request per cycle while rsp
// accepts; a last-row request yields up to three quads, paced by the one rsp port.
// Reset is synchronous: 640x480 at 4 bytes per pixel, position zero, buffers
// empty. The line memories are not cleared and need no clearing pass.
module scale2x_pixel_upscaler #(
   parameter int MAX_WIDTH  = scl2x_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = scl2x_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [scl2x_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [scl2x_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [scl2x_pkg::PIXEL_W-1:0]       req_tdata,   // pixel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // center_row, center_col, top_left, top_right, bottom_left, bottom_right
   output logic [scl2x_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                rsp_tlast,   // last_of_run
   output logic                                rsp_tuser    // end_of_image
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = CW + 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HW = RW + 1;
   localparam int PAD_W = scl2x_pkg::RSP_TDATA_W - 2 * scl2x_pkg::POS_W
                        - 4 * scl2x_pkg::PIXEL_W - 1 + 1;

   logic [scl2x_pkg::DIM_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [scl2x_pkg::BPP_W-1:0] bpp_ff, bpp_in;
   logic                        restart;
   logic [WW-1:0]               eff_w;
   logic [HW-1:0]               eff_h;
   logic [scl2x_pkg::PIXEL_W-1:0] pixel;
   logic                        q_ready;
   scl2x_pkg::batch_type        batch;
   scl2x_pkg::quad_type         quads [scl2x_pkg::QUADS_MAX];
   scl2x_pkg::quad_type         rsp_quad;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      restart   = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            scl2x_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata;
               restart  = 1'b1;
            end
            scl2x_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata;
               restart   = 1'b1;
            end
            scl2x_pkg::CSR_BYTES_PER_PIXEL: begin
               bpp_in = csr_wdata[scl2x_pkg::BPP_W-1:0];
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= scl2x_pkg::RESET_WIDTH;
         height_ff <= scl2x_pkg::RESET_HEIGHT;
         bpp_ff    <= scl2x_pkg::RESET_BPP;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         bpp_ff    <= bpp_in;
      end
   end

   // A size of zero counts as one; sizes above the maximum are clamped.
   always_comb begin
      if (width_ff == '0) begin
         eff_w = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = HW'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(height_ff);
      end
   end

   assign pixel = scl2x_pkg::mask_pixel(bpp_ff, req_tdata);

   scl2x_lines #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_lines (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .eff_w     (eff_w),
      .eff_h     (eff_h),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pixel  (pixel),
      .out_ready (q_ready),
      .batch     (batch),
      .quads     (quads)
   );

   scl2x_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .batch     (batch),
      .quads     (quads),
      .ready     (q_ready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_quad  (rsp_quad),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {{PAD_W{1'b0}},
                       rsp_quad.pix.br, rsp_quad.pix.bl,
                       rsp_quad.pix.tr, rsp_quad.pix.tl,
                       rsp_quad.col, rsp_quad.row};
   assign rsp_tuser = rsp_quad.eoi;

endmodule
